@@ design/pdp11_instruction_decoder_macros.svh @@
// Assertion macros shared by the decoder checker.
// No dependencies; include by bare file name.
`ifndef PDP11_INSTRUCTION_DECODER_MACROS_SVH
`define PDP11_INSTRUCTION_DECODER_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PDP11D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset.
`define PDP11D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pdp11d_pkg.sv @@
// Shared types and constants for the PDP-11 instruction decoder.
// No dependencies.
package pdp11d_pkg;

   typedef enum logic [6:0] {
      MN_DATA = 7'd0,
      MN_MOV, MN_CMP, MN_BIT, MN_BIC, MN_BIS, MN_ADD,
      MN_MOVB, MN_CMPB, MN_BITB, MN_BICB, MN_BISB, MN_SUB,
      MN_BR, MN_BNE, MN_BEQ, MN_BGE, MN_BLT, MN_BGT, MN_BLE,
      MN_BPL, MN_BMI, MN_BHI, MN_BLOS, MN_BVC, MN_BVS, MN_BCC, MN_BCS,
      MN_CLR, MN_COM, MN_INC, MN_DEC, MN_NEG, MN_ADC, MN_SBC, MN_TST,
      MN_ROR, MN_ROL, MN_ASR, MN_ASL,
      MN_CLRB, MN_COMB, MN_INCB, MN_DECB, MN_NEGB, MN_ADCB, MN_SBCB, MN_TSTB,
      MN_RORB, MN_ROLB, MN_ASRB, MN_ASLB,
      MN_MARK, MN_MFPI, MN_MTPI, MN_SXT,
      MN_MTPS, MN_MFPD, MN_MTPD, MN_MFPS,
      MN_MUL, MN_DIV, MN_ASH, MN_ASHC, MN_XOR, MN_FIS, MN_CIS, MN_SOB,
      MN_JSR, MN_JMP, MN_RTS, MN_SWAB, MN_EMT, MN_TRAP,
      MN_NOP, MN_CL, MN_SE,
      MN_HALT, MN_WAIT, MN_RTI, MN_BPT, MN_IOT, MN_RESET, MN_RTT
   } mnem_type;

   typedef enum logic [2:0] {
      FORM_NONE     = 3'd0,
      FORM_ONE      = 3'd1,
      FORM_TWO      = 3'd2,
      FORM_REG_OPND = 3'd3,
      FORM_REG_TGT  = 3'd4,
      FORM_TARGET   = 3'd5,
      FORM_NUMBER   = 3'd6,
      FORM_REG      = 3'd7
   } form_type;

   localparam logic [2:0] MODE_AUTOINC     = 3'd2;
   localparam logic [2:0] MODE_AUTOINC_DEF = 3'd3;
   localparam logic [2:0] MODE_INDEX       = 3'd6;
   localparam logic [2:0] REG_PC           = 3'd7;
   localparam logic [2:0] LEN_BASE         = 3'd2;
   localparam logic [2:0] LEN_ONE_EXT      = 3'd4;
   localparam logic [2:0] LEN_TWO_EXT      = 3'd6;
   localparam logic [2:0] SUB_SOB          = 3'd7;
   localparam logic [3:0] KIND_MARK        = 4'd12;
   localparam logic [5:0] SINGLE_BASE      = 6'o50;
   localparam logic [15:0] OP_NOP          = 16'o000240;

   typedef struct packed {
      logic [15:0] opcode;
      logic [15:0] address;
      logic [15:0] next_word;
      logic [15:0] word_after;
   } req_type;

   typedef struct packed {
      mnem_type    mnemonic;
      form_type    operand_form;
      logic [2:0]  src_mode;
      logic [2:0]  src_reg;
      logic [2:0]  dst_mode;
      logic [2:0]  dst_reg;
      logic [15:0] src_number;
      logic [15:0] dst_number;
      logic [15:0] target;
      logic [7:0]  small_number;
      logic [2:0]  length;
   } rsp_type;

   typedef struct packed {
      logic        uses;
      logic [2:0]  mode;
      logic [2:0]  regn;
      logic [15:0] number;
   } opnd_type;

endpackage

@@ design/pdp11d_req_if.sv @@
// Request channel of the decoder: valid/ready plus instruction fields.
// No dependencies.
interface pdp11d_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [15:0] address;
   logic [15:0] next_word;
   logic [15:0] word_after;

   modport source (output valid, output opcode, output address,
                   output next_word, output word_after, input ready);
   modport sink   (input valid, input opcode, input address,
                   input next_word, input word_after, output ready);
endinterface

@@ design/pdp11d_rsp_if.sv @@
// Result channel of the decoder: valid/ready plus decoded fields.
// No dependencies.
interface pdp11d_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  mnemonic;
   logic [2:0]  operand_form;
   logic [2:0]  src_mode;
   logic [2:0]  src_reg;
   logic [2:0]  dst_mode;
   logic [2:0]  dst_reg;
   logic [15:0] src_number;
   logic [15:0] dst_number;
   logic [15:0] target;
   logic [7:0]  small_number;
   logic [2:0]  length;

   modport source (output valid, output mnemonic, output operand_form,
                   output src_mode, output src_reg, output dst_mode, output dst_reg,
                   output src_number, output dst_number, output target,
                   output small_number, output length, input ready);
   modport sink   (input valid, input mnemonic, input operand_form,
                   input src_mode, input src_reg, input dst_mode, input dst_reg,
                   input src_number, input dst_number, input target,
                   input small_number, input length, output ready);
endinterface

@@ design/pdp11d_opnd.sv @@
// Operand specifier decode: mode, register and extension word use.
// Depends on pdp11d_pkg.
module pdp11d_opnd import pdp11d_pkg::*; (
   input  logic [5:0]  spec,
   input  logic        prior,
   input  logic [15:0] address,
   input  logic [15:0] next_word,
   input  logic [15:0] word_after,
   output opnd_type    opnd
);
   logic [2:0]  m;
   logic [2:0]  r;
   logic [15:0] word;
   logic [2:0]  len_after;
   logic        uses;
   logic        pc_rel;

   assign m = spec[5:3];
   assign r = spec[2:0];
   assign uses = (m >= MODE_INDEX) ||
                 ((m == MODE_AUTOINC || m == MODE_AUTOINC_DEF) && r == REG_PC);
   assign pc_rel = (m >= MODE_INDEX) && (r == REG_PC);
   // an earlier operand already took next_word
   assign word = prior ? word_after : next_word;
   assign len_after = prior ? LEN_TWO_EXT : LEN_ONE_EXT;

   always_comb begin
      opnd.uses = uses;
      opnd.mode = m;
      opnd.regn = r;
      if (!uses) begin
         opnd.number = '0;
      end else if (pc_rel) begin
         opnd.number = address + {13'd0, len_after} + word;
      end else begin
         opnd.number = word;
      end
   end
endmodule

@@ design/pdp11d_core.sv @@
// Instruction group decode from one registered request to one result.
// Depends on pdp11d_pkg and pdp11d_opnd.
module pdp11d_core import pdp11d_pkg::*; (
   input  req_type req,
   output rsp_type rsp
);
   logic [15:0] op;
   logic [15:0] pc;
   logic        dbl;
   logic [3:0]  kind;
   logic [15:0] disp;
   opnd_type    src_op;
   opnd_type    dst_op;

   assign op   = req.opcode;
   assign pc   = req.address + 16'd2;
   assign dbl  = (op[14:12] != 3'd0) && (op[14:12] != 3'd7);
   assign kind = 4'(op[11:6] - SINGLE_BASE);
   assign disp = {{7{op[7]}}, op[7:0], 1'b0};

   pdp11d_opnd u_src (
      .spec       (op[11:6]),
      .prior      (1'b0),
      .address    (req.address),
      .next_word  (req.next_word),
      .word_after (req.word_after),
      .opnd       (src_op)
   );

   pdp11d_opnd u_dst (
      .spec       (op[5:0]),
      .prior      (dbl && src_op.uses),
      .address    (req.address),
      .next_word  (req.next_word),
      .word_after (req.word_after),
      .opnd       (dst_op)
   );

   always_comb begin
      rsp = '0;
      rsp.mnemonic = MN_DATA;
      rsp.operand_form = FORM_NONE;
      rsp.length = LEN_BASE;
      case (op) inside
         [16'o010000:16'o067777], [16'o110000:16'o167777]: begin
            rsp.mnemonic = mnem_type'((op[15] ? 7'(MN_MOVB) : 7'(MN_MOV))
                                      + {4'd0, op[14:12]} - 7'd1);
            rsp.operand_form = FORM_TWO;
            rsp.src_mode = src_op.mode;
            rsp.src_reg = src_op.regn;
            rsp.src_number = src_op.number;
            rsp.dst_mode = dst_op.mode;
            rsp.dst_reg = dst_op.regn;
            rsp.dst_number = dst_op.number;
            rsp.length = LEN_BASE + (src_op.uses ? 3'd2 : 3'd0)
                                  + (dst_op.uses ? 3'd2 : 3'd0);
         end
         [16'o000400:16'o003777], [16'o100000:16'o103777]: begin
            rsp.mnemonic = mnem_type'(op[15] ? 7'(MN_BPL) + {4'd0, op[10:8]}
                                             : 7'(MN_BR) + {4'd0, op[10:8]} - 7'd1);
            rsp.operand_form = FORM_TARGET;
            rsp.target = pc + disp;
         end
         [16'o005000:16'o006777], [16'o105000:16'o106777]: begin
            if (kind < KIND_MARK) begin
               rsp.mnemonic = mnem_type'((op[15] ? 7'(MN_CLRB) : 7'(MN_CLR))
                                         + {3'd0, kind});
            end else begin
               rsp.mnemonic = mnem_type'((op[15] ? 7'(MN_MTPS) : 7'(MN_MARK))
                                         + {3'd0, kind} - {3'd0, KIND_MARK});
            end
            if (!op[15] && kind == KIND_MARK) begin
               rsp.operand_form = FORM_NUMBER;
               rsp.small_number = {2'd0, op[5:0]};
            end else begin
               rsp.operand_form = FORM_ONE;
               rsp.dst_mode = dst_op.mode;
               rsp.dst_reg = dst_op.regn;
               rsp.dst_number = dst_op.number;
               rsp.length = dst_op.uses ? LEN_ONE_EXT : LEN_BASE;
            end
         end
         [16'o070000:16'o077777]: begin
            rsp.mnemonic = mnem_type'(7'(MN_MUL) + {4'd0, op[11:9]});
            rsp.src_reg = op[8:6];
            if (op[11:9] == SUB_SOB) begin
               rsp.operand_form = FORM_REG_TGT;
               rsp.target = pc - {9'd0, op[5:0], 1'b0};
            end else begin
               rsp.operand_form = FORM_REG_OPND;
               rsp.dst_mode = dst_op.mode;
               rsp.dst_reg = dst_op.regn;
               rsp.dst_number = dst_op.number;
               rsp.length = dst_op.uses ? LEN_ONE_EXT : LEN_BASE;
            end
         end
         [16'o004000:16'o004777]: begin
            rsp.mnemonic = MN_JSR;
            rsp.operand_form = FORM_REG_OPND;
            rsp.src_reg = op[8:6];
            rsp.dst_mode = dst_op.mode;
            rsp.dst_reg = dst_op.regn;
            rsp.dst_number = dst_op.number;
            rsp.length = dst_op.uses ? LEN_ONE_EXT : LEN_BASE;
         end
         [16'o000100:16'o000177], [16'o000300:16'o000377]: begin
            rsp.mnemonic = op[7] ? MN_SWAB : MN_JMP;
            rsp.operand_form = FORM_ONE;
            rsp.dst_mode = dst_op.mode;
            rsp.dst_reg = dst_op.regn;
            rsp.dst_number = dst_op.number;
            rsp.length = dst_op.uses ? LEN_ONE_EXT : LEN_BASE;
         end
         [16'o000200:16'o000207]: begin
            rsp.mnemonic = MN_RTS;
            rsp.operand_form = FORM_REG;
            rsp.src_reg = op[2:0];
         end
         [16'o104000:16'o104777]: begin
            rsp.mnemonic = op[8] ? MN_TRAP : MN_EMT;
            rsp.operand_form = FORM_NUMBER;
            rsp.small_number = op[7:0];
         end
         [16'o000240:16'o000277]: begin
            if (op == OP_NOP) begin
               rsp.mnemonic = MN_NOP;
            end else begin
               // bit 4 picks set vs clear, low four bits are the NZVC mask
               rsp.mnemonic = op[4] ? MN_SE : MN_CL;
               rsp.small_number = {3'd0, op[4:0]};
            end
         end
         [16'o000000:16'o000006]: begin
            rsp.mnemonic = mnem_type'(7'(MN_HALT) + {4'd0, op[2:0]});
         end
         default: begin
            rsp.mnemonic = MN_DATA;
         end
      endcase
   end
endmodule

@@ design/pdp11_instruction_decoder.sv @@
// PDP-11 instruction decoder, top level: request register, decode, result register.
// Decode is a single pass of logic between the request and result registers.
// Throughput: one request per cycle unless the result is stalled.
// Ready drops only when both registers hold data and the result is stalled.
// Synchronous reset clears both valid flags; payload registers are not reset.
module pdp11_instruction_decoder import pdp11d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pdp11d_req_if.sink    req_ch,
   pdp11d_rsp_if.source  rsp_ch
);
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type dec_rsp;
   logic    advance;
   logic    accept;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= '{opcode: req_ch.opcode, address: req_ch.address,
                         next_word: req_ch.next_word, word_after: req_ch.word_after};
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= dec_rsp;
      end
   end

   pdp11d_core u_core (
      .req (in_data_ff),
      .rsp (dec_rsp)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.mnemonic     = out_data_ff.mnemonic;
   assign rsp_ch.operand_form = out_data_ff.operand_form;
   assign rsp_ch.src_mode     = out_data_ff.src_mode;
   assign rsp_ch.src_reg      = out_data_ff.src_reg;
   assign rsp_ch.dst_mode     = out_data_ff.dst_mode;
   assign rsp_ch.dst_reg      = out_data_ff.dst_reg;
   assign rsp_ch.src_number   = out_data_ff.src_number;
   assign rsp_ch.dst_number   = out_data_ff.dst_number;
   assign rsp_ch.target       = out_data_ff.target;
   assign rsp_ch.small_number = out_data_ff.small_number;
   assign rsp_ch.length       = out_data_ff.length;
endmodule

@@ design/pdp11d_chk.sv @@
// Port-level checker for the decoder and its bind to the top level.
// Depends on pdp11_instruction_decoder_macros.svh.
`include "pdp11_instruction_decoder_macros.svh"

module pdp11d_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_mnemonic,
   input logic [2:0]  rsp_length,
   input logic [15:0] rsp_target,
   input logic [15:0] rsp_src_number,
   input logic [15:0] rsp_dst_number
);
   logic        req_fire;
   logic        rsp_stall;
   logic [58:0] rsp_word;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_valid, rsp_mnemonic, rsp_length, rsp_target,
                       rsp_src_number, rsp_dst_number};

   `PDP11D_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "valid after reset")
   `PDP11D_ASSERT(a_latency, clock, reset, req_fire ##1 rsp_ready |=> rsp_valid, "result late")
   `PDP11D_ASSERT(a_backpressure, clock, reset, !req_ready |-> rsp_stall, "bad backpressure")
   `PDP11D_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_word), "result moved")
endmodule

bind pdp11_instruction_decoder pdp11d_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_mnemonic   (rsp_ch.mnemonic),
   .rsp_length     (rsp_ch.length),
   .rsp_target     (rsp_ch.target),
   .rsp_src_number (rsp_ch.src_number),
   .rsp_dst_number (rsp_ch.dst_number)
);

@@ verif/tb_pdp11_instruction_decoder.sv @@
// Self-checking testbench for pdp11_instruction_decoder: directed and random requests.
// A scoreboard class predicts each decode and checks results in order.
// Depends on pdp11d_pkg, pdp11d_req_if, pdp11d_rsp_if and the decoder top level.
module tb_pdp11_instruction_decoder;
   import pdp11d_pkg::*;

   localparam int RANDOM_REQUESTS = 600;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int DIRECTED_COUNT  = 28;

   localparam logic [15:0] DIRECTED_OPS [0:DIRECTED_COUNT-1] = '{
      16'o012737, 16'o066767, 16'o167777, 16'o000777, 16'o103600, 16'o005000,
      16'o106367, 16'o006477, 16'o106427, 16'o070127, 16'o077777, 16'o074567,
      16'o004767, 16'o000137, 16'o000207, 16'o000300, 16'o104000, 16'o104777,
      16'o000240, 16'o000260, 16'o000257, 16'o000006, 16'o000000, 16'o000007,
      16'o000237, 16'o007000, 16'o107000, 16'o177777
   };

   class decode_scoreboard;
      rsp_type expected_decodes[$];
      int      fail_count;
      int      result_index;

      function new();
         fail_count   = 0;
         result_index = 0;
      endfunction

      // Operand specifier; pulls an extension word when the mode needs one.
      function opnd_type take_spec(logic [5:0] spec, req_type rq, inout logic [2:0] ln);
         opnd_type    o;
         logic [15:0] word;
         o.mode   = spec[5:3];
         o.regn   = spec[2:0];
         o.number = '0;
         o.uses   = (o.mode >= MODE_INDEX) ||
                    ((o.mode == MODE_AUTOINC || o.mode == MODE_AUTOINC_DEF) &&
                     o.regn == REG_PC);
         if (o.uses) begin
            word = (ln >= LEN_ONE_EXT) ? rq.word_after : rq.next_word;
            ln   = ln + 3'd2;
            o.number = (o.mode >= MODE_INDEX && o.regn == REG_PC) ?
                       16'(rq.address + 16'(ln) + word) : word;
         end
         return o;
      endfunction

      function rsp_type predict_decode(req_type rq);
         rsp_type     d;
         opnd_type    o;
         logic [15:0] op;
         logic [15:0] pc;
         logic [15:0] disp;
         logic [3:0]  top;
         logic [2:0]  ln;
         logic [2:0]  sub;
         logic [5:0]  kind;
         logic        byteop;
         logic        has_dst;
         d       = '0;
         op      = rq.opcode;
         pc      = rq.address + 16'd2;
         top     = op[15:12];
         ln      = LEN_BASE;
         has_dst = 1'b0;
         if ((top >= 4'd1 && top <= 4'd6) || (top >= 4'd9 && top <= 4'd14)) begin
            d.mnemonic     = (top >= 4'd8) ? mnem_type'(MN_MOVB + top[2:0] - 1)
                                           : mnem_type'(MN_MOV + top[2:0] - 1);
            d.operand_form = FORM_TWO;
            o = take_spec(op[11:6], rq, ln);
            d.src_mode   = o.mode;
            d.src_reg    = o.regn;
            d.src_number = o.number;
            has_dst = 1'b1;
         end else if ((op >= 16'o000400 && op < 16'o004000) ||
                      (op >= 16'o100000 && op < 16'o104000)) begin
            disp = {{8{op[7]}}, op[7:0]};
            d.mnemonic     = op[15] ? mnem_type'(MN_BPL + op[10:8])
                                    : mnem_type'(MN_BR + op[10:8] - 1);
            d.operand_form = FORM_TARGET;
            d.target       = pc + (disp << 1);
         end else if ((op >= 16'o005000 && op < 16'o007000) ||
                      (op >= 16'o105000 && op < 16'o107000)) begin
            byteop = op[15];
            kind   = op[11:6] - SINGLE_BASE;
            if (kind < 6'(KIND_MARK))
               d.mnemonic = mnem_type'((byteop ? MN_CLRB : MN_CLR) + kind);
            else
               d.mnemonic = mnem_type'((byteop ? MN_MTPS : MN_MARK) + (kind - 12));
            if (!byteop && kind == 6'(KIND_MARK)) begin
               d.operand_form = FORM_NUMBER;
               d.small_number = {2'b00, op[5:0]};
            end else begin
               d.operand_form = FORM_ONE;
               has_dst = 1'b1;
            end
         end else if (top == 4'd7) begin
            sub = op[11:9];
            case (sub)
               3'd0: d.mnemonic = MN_MUL;
               3'd1: d.mnemonic = MN_DIV;
               3'd2: d.mnemonic = MN_ASH;
               3'd3: d.mnemonic = MN_ASHC;
               3'd4: d.mnemonic = MN_XOR;
               3'd5: d.mnemonic = MN_FIS;
               3'd6: d.mnemonic = MN_CIS;
               default: d.mnemonic = MN_SOB;
            endcase
            d.src_reg = op[8:6];
            if (sub == SUB_SOB) begin
               d.operand_form = FORM_REG_TGT;
               d.target       = pc - {9'b0, op[5:0], 1'b0};
            end else begin
               d.operand_form = FORM_REG_OPND;
               has_dst = 1'b1;
            end
         end else if (op >= 16'o004000 && op < 16'o005000) begin
            d.mnemonic     = MN_JSR;
            d.operand_form = FORM_REG_OPND;
            d.src_reg      = op[8:6];
            has_dst = 1'b1;
         end else if ((op >= 16'o000100 && op < 16'o000200) ||
                      (op >= 16'o000300 && op < 16'o000400)) begin
            d.mnemonic     = (op < 16'o000200) ? MN_JMP : MN_SWAB;
            d.operand_form = FORM_ONE;
            has_dst = 1'b1;
         end else if (op >= 16'o000200 && op < 16'o000210) begin
            d.mnemonic     = MN_RTS;
            d.operand_form = FORM_REG;
            d.src_reg      = op[2:0];
         end else if (op >= 16'o104000 && op < 16'o105000) begin
            d.mnemonic     = (op < 16'o104400) ? MN_EMT : MN_TRAP;
            d.operand_form = FORM_NUMBER;
            d.small_number = op[7:0];
         end else if (op >= 16'o000240 && op < 16'o000300) begin
            if (op == OP_NOP) begin
               d.mnemonic = MN_NOP;
            end else begin
               d.mnemonic     = op[4] ? MN_SE : MN_CL;
               d.small_number = {3'b000, op[4:0]};
            end
         end else if (op < 16'o000007) begin
            d.mnemonic = mnem_type'(MN_HALT + op[2:0]);
         end
         if (has_dst) begin
            o = take_spec(op[5:0], rq, ln);
            d.dst_mode   = o.mode;
            d.dst_reg    = o.regn;
            d.dst_number = o.number;
         end
         d.length = ln;
         return d;
      endfunction

      function void note_request(req_type rq);
         expected_decodes.push_back(predict_decode(rq));
      endfunction

      function int pending();
         return expected_decodes.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at result %0d: %s", result_index, msg);
         fail_count++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_decodes.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_decodes.pop_front();
            compare_field("mnemonic", 16'(got.mnemonic), 16'(want.mnemonic));
            compare_field("operand_form", 16'(got.operand_form), 16'(want.operand_form));
            compare_field("src_mode", 16'(got.src_mode), 16'(want.src_mode));
            compare_field("src_reg", 16'(got.src_reg), 16'(want.src_reg));
            compare_field("dst_mode", 16'(got.dst_mode), 16'(want.dst_mode));
            compare_field("dst_reg", 16'(got.dst_reg), 16'(want.dst_reg));
            compare_field("src_number", got.src_number, want.src_number);
            compare_field("dst_number", got.dst_number, want.dst_number);
            compare_field("target", got.target, want.target);
            compare_field("small_number", 16'(got.small_number), 16'(want.small_number));
            compare_field("length", 16'(got.length), 16'(want.length));
         end
         result_index++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   decode_scoreboard sb;

   pdp11d_req_if req_bus();
   pdp11d_rsp_if rsp_bus();

   pdp11_instruction_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75)
         return $urandom_range(1, 3);
      else if (pick < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Operand specifier biased toward PC so the extension-word paths get hit often.
   function automatic logic [5:0] random_spec();
      logic [2:0] m;
      logic [2:0] r;
      m = 3'($urandom_range(0, 7));
      r = ($urandom_range(0, 2) == 0) ? REG_PC : 3'($urandom_range(0, 7));
      return {m, r};
   endfunction

   function automatic req_type random_request();
      req_type    rq;
      logic [3:0] top;
      int         t;
      rq.address    = 16'($urandom_range(0, 65535));
      rq.next_word  = 16'($urandom_range(0, 65535));
      rq.word_after = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 11))
         0: rq.opcode = 16'($urandom_range(0, 65535));
         1: begin
            t   = $urandom_range(1, 12);
            top = (t <= 6) ? 4'(t) : 4'(t + 2);
            rq.opcode = {top, random_spec(), random_spec()};
         end
         2: begin
            if ($urandom_range(0, 1) == 0)
               rq.opcode = {8'($urandom_range(1, 7)), 8'($urandom_range(0, 255))};
            else
               rq.opcode = {5'b10000, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))};
         end
         3: rq.opcode = {1'($urandom_range(0, 1)), 3'b000,
                         6'(SINGLE_BASE + $urandom_range(0, 15)), random_spec()};
         4: rq.opcode = {4'b0111, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         random_spec()};
         5: rq.opcode = {7'b0000100, 3'($urandom_range(0, 7)), random_spec()};
         6: rq.opcode = {8'b0, 1'($urandom_range(0, 1)), 1'b1, random_spec()};
         7: rq.opcode = 16'(16'o000200 + $urandom_range(0, 7));
         8: rq.opcode = 16'(16'o104000 + $urandom_range(0, 511));
         9: rq.opcode = 16'(16'o000240 + $urandom_range(0, 31));
         10: rq.opcode = 16'($urandom_range(0, 7));
         default: begin
            case ($urandom_range(0, 4))
               0: rq.opcode = 16'($urandom_range(16'o000010, 16'o000077));
               1: rq.opcode = 16'($urandom_range(16'o000210, 16'o000237));
               2: rq.opcode = 16'($urandom_range(16'o007000, 16'o007777));
               3: rq.opcode = 16'($urandom_range(16'o107000, 16'o107777));
               default: rq.opcode = 16'($urandom_range(16'o170000, 16'o177777));
            endcase
         end
      endcase
      return rq;
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task drive_request(req_type rq, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= rq.opcode;
      req_bus.address    <= rq.address;
      req_bus.next_word  <= rq.next_word;
      req_bus.word_after <= rq.word_after;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sb.note_request(rq);
   endtask

   function automatic int sender_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return ($urandom_range(0, 1) == 0) ? 0 : idle_length();
   endfunction

   initial begin : request_side
      req_type rq;
      int      burst_left;
      burst_left = 0;
      sb = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= '0;
      req_bus.address    <= '0;
      req_bus.next_word  <= '0;
      req_bus.word_after <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         rq.opcode     = DIRECTED_OPS[i];
         rq.address    = (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'hFFFE);
         rq.next_word  = i[0] ? 16'hFFFF : 16'h0000;
         rq.word_after = ~rq.next_word;
         drive_request(rq, sender_gap(burst_left));
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++)
         drive_request(random_request(), sender_gap(burst_left));
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : result_side
      rsp_type got;
      int      stall_left;
      int      quiet_left;
      stall_left = 0;
      quiet_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.mnemonic     = mnem_type'(rsp_bus.mnemonic);
            got.operand_form = form_type'(rsp_bus.operand_form);
            got.src_mode     = rsp_bus.src_mode;
            got.src_reg      = rsp_bus.src_reg;
            got.dst_mode     = rsp_bus.dst_mode;
            got.dst_reg      = rsp_bus.dst_reg;
            got.src_number   = rsp_bus.src_number;
            got.dst_number   = rsp_bus.dst_number;
            got.target       = rsp_bus.target;
            got.small_number = rsp_bus.small_number;
            got.length       = rsp_bus.length;
            sb.check_response(got);
         end
         // quiet stretches keep ready high for a while
         if (quiet_left > 0)
            quiet_left--;
         else if ($urandom_range(0, 199) == 0)
            quiet_left = $urandom_range(50, 200);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

@@ pdp11_instruction_decoder.f @@
+incdir+design
design/pdp11d_pkg.sv
design/pdp11d_req_if.sv
design/pdp11d_rsp_if.sv
design/pdp11d_opnd.sv
design/pdp11d_core.sv
design/pdp11_instruction_decoder.sv
design/pdp11d_chk.sv
verif/tb_pdp11_instruction_decoder.sv
